[rtl/cssc_pkg.sv]
// Shared types and constants of the conveyor stop station controller.
package cssc_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_BITS       = 16;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;

	localparam logic [CFG_BITS-1:0] RESTART_IGNORE_RST = 16'd1000;
	localparam logic [CFG_BITS-1:0] DEBOUNCE_RST       = 16'd30;

	typedef enum logic {
		REG_RESTART_IGNORE = 1'b0,
		REG_DEBOUNCE       = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_COMMAND = 1'b1
	} op_t;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam logic [7:0] CMD_START   = 8'h53;	// S
	localparam logic [7:0] CMD_RESTART = 8'h52;	// R
	localparam logic [7:0] CMD_STOP    = 8'h58;	// X
	localparam logic [7:0] CMD_EMPTY   = 8'h45;	// E
	localparam logic [7:0] CMD_OBJECT  = 8'h4f;	// O

	typedef enum logic [2:0] {
		EV_NONE           = 3'd0,
		EV_AUTO_START     = 3'd1,
		EV_MANUAL_RESTART = 3'd2,
		EV_STOP_CMD       = 3'd3,
		EV_EMPTY_RESTART  = 3'd4,
		EV_EMPTY_IGNORED  = 3'd5,
		EV_OBJECT_WAIT    = 3'd6,
		EV_SENSOR_STOP    = 3'd7
	} event_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] command_byte;
		logic       sensor_level;
	} item_t;

	typedef struct packed {
		event_t event_code;
		logic   step_pulses_on;
		logic   drive_enable;
		logic   auto_on;
		logic   camera_wait;
	} result_t;

endpackage

[rtl/cssc_ctrl.sv]
// Belt state, tick counters and command decode; one request per cycle while fire is high.
module cssc_ctrl import cssc_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  item_t               item,
	input  logic [CFG_BITS-1:0] restart_ignore_ticks,
	input  logic [CFG_BITS-1:0] debounce_ticks,
	output result_t             res
);

	localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

	logic                  running_q, auto_q, waiting_q, released_q, enable_q, low_active_q;
	logic [TIMER_BITS-1:0] ticks_q, low_ticks_q;

	logic                  running_n, auto_n, waiting_n, released_n, enable_n, low_active_n;
	logic [TIMER_BITS-1:0] ticks_n, low_ticks_n, ticks_inc, low_inc;
	logic                  do_go, do_halt;
	logic [7:0]            cmd;
	event_t                ev;

	assign ticks_inc = (ticks_q == '1) ? ticks_q : TIMER_BITS'(ticks_q + 1'b1);
	assign low_inc   = (low_ticks_q == '1) ? low_ticks_q : TIMER_BITS'(low_ticks_q + 1'b1);
	assign cmd = (item.command_byte >= CHAR_LOWER_A && item.command_byte <= CHAR_LOWER_Z) ?
		8'(item.command_byte - CASE_OFFSET) : item.command_byte;

	always_comb begin
		running_n    = running_q;
		auto_n       = auto_q;
		waiting_n    = waiting_q;
		released_n   = released_q;
		enable_n     = enable_q;
		low_active_n = low_active_q;
		ticks_n      = ticks_q;
		low_ticks_n  = low_ticks_q;
		do_go        = 1'b0;
		do_halt      = 1'b0;
		ev           = EV_NONE;
		unique case (item.operation)
			OP_TICK: begin
				if (running_q) begin
					ticks_n = ticks_inc;
					if (auto_q && (CW'(ticks_inc) >= CW'(restart_ignore_ticks))) begin
						if (item.sensor_level) begin
							released_n   = 1'b1;
							low_active_n = 1'b0;
							low_ticks_n  = '0;
						end else if (released_q) begin
							if (!low_active_q) begin
								low_active_n = 1'b1;
								low_ticks_n  = '0;
							end else begin
								low_ticks_n = low_inc;
								if (CW'(low_inc) >= CW'(debounce_ticks)) begin
									do_halt   = 1'b1;
									waiting_n = 1'b1;
									ev        = EV_SENSOR_STOP;
								end
							end
						end
					end
				end
			end
			OP_COMMAND: begin
				unique case (cmd)
					CMD_START: begin
						auto_n    = 1'b1;
						waiting_n = 1'b0;
						do_go     = 1'b1;
						ev        = EV_AUTO_START;
					end
					CMD_RESTART: begin
						do_go = 1'b1;
						ev    = EV_MANUAL_RESTART;
					end
					CMD_STOP: begin
						auto_n    = 1'b0;
						waiting_n = 1'b0;
						do_halt   = 1'b1;
						ev        = EV_STOP_CMD;
					end
					CMD_EMPTY: begin
						if (auto_q && waiting_q) begin
							waiting_n = 1'b0;
							do_go     = 1'b1;
							ev        = EV_EMPTY_RESTART;
						end else begin
							ev = EV_EMPTY_IGNORED;
						end
					end
					CMD_OBJECT: begin
						if (auto_q) begin
							waiting_n = 1'b1;
							do_halt   = 1'b1;
							ev        = EV_OBJECT_WAIT;
						end
					end
					default: ev = EV_NONE;
				endcase
			end
			default: ev = EV_NONE;
		endcase
		if (do_go && !running_q) begin
			running_n    = 1'b1;
			waiting_n    = 1'b0;
			released_n   = 1'b0;
			ticks_n      = '0;
			low_active_n = 1'b0;
			low_ticks_n  = '0;
			enable_n     = 1'b1;
		end
		if (do_halt) begin
			running_n = 1'b0;
		end
	end

	always_comb begin
		res.event_code     = ev;
		res.step_pulses_on = running_n;
		res.drive_enable   = enable_n;
		res.auto_on        = auto_n;
		res.camera_wait    = waiting_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			auto_q       <= 1'b0;
			waiting_q    <= 1'b0;
			released_q   <= 1'b0;
			enable_q     <= 1'b0;
			low_active_q <= 1'b0;
			ticks_q      <= '0;
			low_ticks_q  <= '0;
		end else if (fire) begin
			running_q    <= running_n;
			auto_q       <= auto_n;
			waiting_q    <= waiting_n;
			released_q   <= released_n;
			enable_q     <= enable_n;
			low_active_q <= low_active_n;
			ticks_q      <= ticks_n;
			low_ticks_q  <= low_ticks_n;
		end
	end

	a_enable_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(enable_q) |-> enable_q)
		else $error("drive enable cleared");

	a_run_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> enable_q)
		else $error("belt running without drive enable");

	a_low_after_release: assert property (@(posedge clk) disable iff (!arst_n)
		low_active_q |-> released_q)
		else $error("low run started before line release");

	a_sensor_stop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ev == EV_SENSOR_STOP) |=> (!running_q && waiting_q && auto_q))
		else $error("sensor stop left wrong flags");

endmodule

[rtl/conveyor_stop_station_controller_top.sv]
// Top level of the conveyor stop station controller: handshake, registers, result stage.
//
// Each request (a 1 ms tick with the sensor sample, or a command byte) yields exactly one
// result. The block takes one request per clock cycle while its results are taken. An
// accepted request sits in the input register until the result stage can advance; then the
// belt flags and counters in cssc_ctrl are updated and its result is loaded into the result
// register, which raises out_valid. While a result waits to be taken, one more request is
// held in the input register before in_ready drops. Registers: 0x0 restart_ignore_ticks,
// 0x4 debounce_ticks, both 16 bits; write them only while no request is in flight.
module conveyor_stop_station_controller_top import cssc_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [7:0]               command_byte,
	input  logic                     sensor_level,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               event_code,
	output logic                     step_pulses_on,
	output logic                     drive_enable,
	output logic                     auto_on,
	output logic                     camera_wait
);

	logic [CFG_BITS-1:0] restart_ignore_q, debounce_q;
	reg_idx_t            reg_idx;
	logic                cfg_write;

	item_t   item_s1;
	logic    valid_s1;
	result_t res, res_q;
	logic    out_valid_q;
	logic    advance, fire;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_ignore_q <= RESTART_IGNORE_RST;
			debounce_q       <= DEBOUNCE_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_RESTART_IGNORE: restart_ignore_q <= pwdata[CFG_BITS-1:0];
				REG_DEBOUNCE:       debounce_q       <= pwdata[CFG_BITS-1:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RESTART_IGNORE: prdata = APB_DATA_BITS'(restart_ignore_q);
			REG_DEBOUNCE:       prdata = APB_DATA_BITS'(debounce_q);
			default:            prdata = '0;
		endcase
	end

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation    <= op_t'(operation);
			item_s1.command_byte <= command_byte;
			item_s1.sensor_level <= sensor_level;
		end
	end

	cssc_ctrl #(
		.TIMER_BITS(TIMER_BITS)
	) u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.fire                (fire),
		.item                (item_s1),
		.restart_ignore_ticks(restart_ignore_q),
		.debounce_ticks      (debounce_q),
		.res                 (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_code     = res_q.event_code;
	assign step_pulses_on = res_q.step_pulses_on;
	assign drive_enable   = res_q.drive_enable;
	assign auto_on        = res_q.auto_on;
	assign camera_wait    = res_q.camera_wait;

endmodule

[test/tb.sv]
// Testbench for the conveyor stop station controller: directed table, random requests, predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cssc_pkg::*;

	localparam int CYCLE_LIMIT      = 1_500_000;
	localparam int RANDOM_PHASES    = 5;
	localparam int REQS_PER_PHASE   = 400;
	localparam int HOLD_CYCLES      = 300;
	localparam int SOAK_HIGH_TICKS  = 80;
	localparam int SOAK_LOW_TICKS   = 60;
	localparam int SOAK_IGNORE      = 50;
	localparam int SOAK_DEBOUNCE    = 20;
	localparam int MAX_WAIT         = 11;

	typedef struct {
		item_t   it;
		bit      fixed;
		result_t res;
	} stim_row_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     psel         = 1'b0;
	logic                     penable      = 1'b0;
	logic                     pwrite       = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr        = '0;
	logic [APB_DATA_BITS-1:0] pwdata       = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid     = 1'b0;
	logic                     in_ready;
	logic                     operation    = 1'b0;
	logic [7:0]               command_byte = '0;
	logic                     sensor_level = 1'b0;
	logic                     out_valid;
	logic                     out_ready    = 1'b0;
	logic [2:0]               event_code;
	logic                     step_pulses_on;
	logic                     drive_enable;
	logic                     auto_on;
	logic                     camera_wait;

	// belt model state
	bit                        run_q     = 1'b0;
	bit                        auto_q    = 1'b0;
	bit                        wait_q    = 1'b0;
	bit                        rel_q     = 1'b0;
	bit                        en_q      = 1'b0;
	bit                        low_act_q = 1'b0;
	logic [TIMER_BITS_DEF-1:0] ticks_q   = '0;
	logic [TIMER_BITS_DEF-1:0] low_cnt_q = '0;
	logic [CFG_BITS-1:0]       ignore_q  = RESTART_IGNORE_RST;
	logic [CFG_BITS-1:0]       debounce_q = DEBOUNCE_RST;

	result_t     pending_results[$];
	stim_row_t   directed[$];
	int          phase_b_start;
	int unsigned fails       = 0;
	int unsigned cycle_count = 0;
	bit          fast        = 1'b0;
	bit          hold_pending = 1'b0;
	bit          sensor_run  = 1'b1;

	conveyor_stop_station_controller_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.command_byte   (command_byte),
		.sensor_level   (sensor_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_code     (event_code),
		.step_pulses_on (step_pulses_on),
		.drive_enable   (drive_enable),
		.auto_on        (auto_on),
		.camera_wait    (camera_wait)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int draw_wait();
		return fast ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	function automatic void start_belt();
		if (!run_q) begin
			run_q     = 1'b1;
			wait_q    = 1'b0;
			rel_q     = 1'b0;
			ticks_q   = '0;
			low_act_q = 1'b0;
			low_cnt_q = '0;
			en_q      = 1'b1;
		end
	endfunction

	function automatic result_t predict_belt(item_t it);
		logic [7:0] c;
		event_t     ev;
		result_t    r;
		ev = EV_NONE;
		if (it.operation == OP_TICK) begin
			if (run_q) begin
				if (ticks_q != '1)
					ticks_q = ticks_q + 1'b1;
				if (auto_q && ticks_q >= ignore_q) begin
					if (it.sensor_level) begin
						rel_q     = 1'b1;
						low_act_q = 1'b0;
						low_cnt_q = '0;
					end else if (rel_q) begin
						if (!low_act_q) begin
							low_act_q = 1'b1;
							low_cnt_q = '0;
						end else begin
							if (low_cnt_q != '1)
								low_cnt_q = low_cnt_q + 1'b1;
							if (low_cnt_q >= debounce_q) begin
								run_q  = 1'b0;
								wait_q = 1'b1;
								ev     = EV_SENSOR_STOP;
							end
						end
					end
				end
			end
		end else begin
			c = it.command_byte;
			if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
				c = c - CASE_OFFSET;
			case (c)
				CMD_START: begin
					auto_q = 1'b1;
					wait_q = 1'b0;
					start_belt();
					ev = EV_AUTO_START;
				end
				CMD_RESTART: begin
					start_belt();
					ev = EV_MANUAL_RESTART;
				end
				CMD_STOP: begin
					auto_q = 1'b0;
					wait_q = 1'b0;
					run_q  = 1'b0;
					ev = EV_STOP_CMD;
				end
				CMD_EMPTY: begin
					if (auto_q && wait_q) begin
						wait_q = 1'b0;
						start_belt();
						ev = EV_EMPTY_RESTART;
					end else begin
						ev = EV_EMPTY_IGNORED;
					end
				end
				CMD_OBJECT: begin
					if (auto_q) begin
						wait_q = 1'b1;
						run_q  = 1'b0;
						ev = EV_OBJECT_WAIT;
					end
				end
				default: ;
			endcase
		end
		r.event_code     = ev;
		r.step_pulses_on = run_q;
		r.drive_enable   = en_q;
		r.auto_on        = auto_q;
		r.camera_wait    = wait_q;
		return r;
	endfunction

	function automatic item_t next_random_item();
		item_t it;
		int    pick;
		if ($urandom_range(0, 5) == 0)
			sensor_run = ~sensor_run;
		it.operation    = ($urandom_range(0, 99) < 75) ? OP_TICK : OP_COMMAND;
		it.command_byte = 8'($urandom);
		it.sensor_level = sensor_run;
		if (it.operation == OP_COMMAND && $urandom_range(0, 7) != 0) begin
			pick = $urandom_range(0, 15);
			if (pick < 3)
				it.command_byte = CMD_START;
			else if (pick < 5)
				it.command_byte = CMD_RESTART;
			else if (pick < 6)
				it.command_byte = CMD_STOP;
			else if (pick < 12)
				it.command_byte = CMD_EMPTY;
			else
				it.command_byte = CMD_OBJECT;
			if ($urandom_range(0, 1) == 1)
				it.command_byte = it.command_byte | CASE_OFFSET;
		end
		return it;
	endfunction

	task automatic add_row(input op_t op, input logic [7:0] b, input logic s, input bit fixed,
			input event_t ev, input bit run, input bit en, input bit au, input bit cw);
		stim_row_t row;
		row.it.operation        = op;
		row.it.command_byte     = b;
		row.it.sensor_level     = s;
		row.fixed               = fixed;
		row.res.event_code      = ev;
		row.res.step_pulses_on  = run;
		row.res.drive_enable    = en;
		row.res.auto_on         = au;
		row.res.camera_wait     = cw;
		directed.push_back(row);
	endtask

	task automatic send_request(input item_t it, input bit fixed, input result_t res);
		int      gap;
		result_t pred;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= it.operation;
		command_byte <= it.command_byte;
		sensor_level <= it.sensor_level;
		do @(posedge clk); while (!in_ready);
		pred = predict_belt(it);
		pending_results.push_back(fixed ? res : pred);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
			input logic [APB_DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_BITS-1:0] !== data[CFG_BITS-1:0]) begin
			$error("prdata: expected %0h, got %0h", data[CFG_BITS-1:0], prdata[CFG_BITS-1:0]);
			fails++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [CFG_BITS-1:0] ignore, input logic [CFG_BITS-1:0] deb);
		apb_write(APB_ADDR_BITS'(4 * REG_RESTART_IGNORE), APB_DATA_BITS'(ignore));
		apb_write(APB_ADDR_BITS'(4 * REG_DEBOUNCE), APB_DATA_BITS'(deb));
		ignore_q   = ignore;
		debounce_q = deb;
	endtask

	// result checker
	initial begin
		int      stall;
		result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (hold_pending) begin
				hold_pending = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$error("result with no request pending: event_code %0d", event_code);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (event_code !== want.event_code) begin
					$error("event_code: expected %0d, got %0d", want.event_code, event_code);
					fails++;
				end
				if (step_pulses_on !== want.step_pulses_on) begin
					$error("step_pulses_on: expected %0b, got %0b", want.step_pulses_on,
						step_pulses_on);
					fails++;
				end
				if (drive_enable !== want.drive_enable) begin
					$error("drive_enable: expected %0b, got %0b", want.drive_enable, drive_enable);
					fails++;
				end
				if (auto_on !== want.auto_on) begin
					$error("auto_on: expected %0b, got %0b", want.auto_on, auto_on);
					fails++;
				end
				if (camera_wait !== want.camera_wait) begin
					$error("camera_wait: expected %0b, got %0b", want.camera_wait, camera_wait);
					fails++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int      i;
		int      ph;
		int      n;
		item_t   it;
		result_t none;
		none = '0;

		// at reset timing
		add_row(OP_TICK,    8'hFF,                   1'b1, 1'b1, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, 8'h00,                   1'b0, 1'b1, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_OBJECT | CASE_OFFSET, 1'b1, 1'b1, EV_NONE,          0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_EMPTY,               1'b0, 1'b1, EV_EMPTY_IGNORED,  0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_RESTART,             1'b1, 1'b1, EV_MANUAL_RESTART, 1, 1, 0, 0);
		add_row(OP_TICK,    8'h00,                   1'b0, 1'b1, EV_NONE,           1, 1, 0, 0);
		add_row(OP_COMMAND, CMD_STOP | CASE_OFFSET,  1'b0, 1'b1, EV_STOP_CMD,       0, 1, 0, 0);
		add_row(OP_COMMAND, CMD_START | 8'h80,       1'b1, 1'b1, EV_NONE,           0, 1, 0, 0);
		phase_b_start = directed.size();
		// zero ignore window, zero debounce
		add_row(OP_COMMAND, CMD_START,               1'b0, 1'b1, EV_AUTO_START,     1, 1, 1, 0);
		add_row(OP_TICK,    8'h5A,                   1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_TICK,    8'hA5,                   1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_TICK,    8'h00,                   1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_TICK,    8'hFF,                   1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_EMPTY | CASE_OFFSET, 1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_OBJECT,              1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_EMPTY,               1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_START | CASE_OFFSET, 1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_RESTART | CASE_OFFSET, 1'b0, 1'b0, EV_NONE,         0, 0, 0, 0);
		add_row(OP_COMMAND, CHAR_LOWER_Z + 8'd1,     1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CHAR_LOWER_A - 8'd1,     1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_STOP,                1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, CMD_EMPTY,               1'b0, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_TICK,    8'h3C,                   1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);
		add_row(OP_COMMAND, 8'h80,                   1'b1, 1'b0, EV_NONE,           0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < phase_b_start; i++)
			send_request(directed[i].it, directed[i].fixed, directed[i].res);
		wait_drained();
		set_timing('0, '0);
		for (i = phase_b_start; i < directed.size(); i++)
			send_request(directed[i].it, directed[i].fixed, directed[i].res);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			if (ph == 0)
				set_timing('0, '0);
			else
				set_timing(CFG_BITS'($urandom_range(0, 40)), CFG_BITS'($urandom_range(0, 5)));
			fast = (ph == 3);
			if (ph == 2)
				hold_pending = 1'b1;
			for (n = 0; n < REQS_PER_PHASE; n++) begin
				if (ph == 1 && n == REQS_PER_PHASE / 2)
					wait_drained();
				send_request(next_random_item(), 1'b0, none);
			end
		end

		// long ignore window and debounce run, back to back
		wait_drained();
		fast = 1'b1;
		set_timing(CFG_BITS'(SOAK_IGNORE), CFG_BITS'(SOAK_DEBOUNCE));
		it.operation    = OP_COMMAND;
		it.command_byte = CMD_START;
		it.sensor_level = 1'b1;
		send_request(it, 1'b0, none);
		it.operation = OP_TICK;
		for (n = 0; n < SOAK_HIGH_TICKS; n++) begin
			it.command_byte = 8'($urandom);
			send_request(it, 1'b0, none);
		end
		it.sensor_level = 1'b0;
		for (n = 0; n < SOAK_LOW_TICKS; n++) begin
			it.command_byte = 8'($urandom);
			send_request(it, 1'b0, none);
		end
		it.operation    = OP_COMMAND;
		it.command_byte = CMD_STOP;
		send_request(it, 1'b0, none);
		fast = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
rtl/cssc_pkg.sv
rtl/cssc_ctrl.sv
rtl/conveyor_stop_station_controller_top.sv
test/tb.sv
